@@ design/rqt_pkg.sv @@
// ----------------------------------------------------------------------------
// rqt_pkg
// shared widths, constants and rounding helpers for the relative quaternion
// to transform pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rqt_pkg;

  localparam int unsigned QW      = 16;        // input quaternion component
  localparam int unsigned PRW     = 32;        // 16x16 product
  localparam int unsigned PW      = 34;        // four-term product sum
  localparam int unsigned MW      = 33;        // magnitude of a product sum
  localparam int unsigned NW      = 33;        // squared norm
  localparam int unsigned FRAC    = 14;
  localparam int unsigned NUMW    = 48;        // dividend: mag * 2^15 + n
  localparam int unsigned DENW    = NW + 1;    // divisor: 2 * n
  localparam int unsigned QBITS   = 32;        // quotient bits produced
  localparam int unsigned CMPW    = DENW + QBITS - 1;
  localparam int unsigned EW      = 32;        // error quaternion component
  localparam int unsigned TW      = 64;        // matrix term
  localparam int unsigned RW      = 16;        // rotation entry
  localparam int unsigned SW      = 17;        // translation entry
  localparam int unsigned AW      = 32;        // arm length times rotation

  localparam logic [EW-1:0]        E_LIMIT  = 32'h4000_0000;
  localparam logic signed [TW-1:0] ONE_Q28  = 64'sd268435456;
  localparam logic signed [TW-1:0] ROT_MAX  = 64'sd32767;
  localparam logic signed [TW-1:0] ROT_MIN  = -64'sd32768;
  localparam logic signed [TW-1:0] SHF_MAX  = 64'sd65535;
  localparam logic signed [TW-1:0] SHF_MIN  = -64'sd65536;

  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned DIV_STAGES   = QBITS + 2;
  localparam int unsigned MAT_STAGES   = 5;
  localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STAGES + MAT_STAGES;

  typedef logic signed [QW-1:0] q16_t;
  typedef logic signed [EW-1:0] e_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [SW-1:0] shf_t;

  // control that travels with a quaternion pair through the divider
  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [3:0] neg;
  } div_ctl_t;

  // divide by 2^14, nearest, ties away from zero
  function automatic logic signed [TW-1:0] rnd14(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] bias;
    bias = v[TW-1] ? 64'sd8191 : 64'sd8192;
    return (v + bias) >>> FRAC;
  endfunction

  function automatic rot_t sat_rot(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = rnd14(v);
    if (r > ROT_MAX) r = ROT_MAX;
    if (r < ROT_MIN) r = ROT_MIN;
    return r[RW-1:0];
  endfunction

  function automatic shf_t sat_shf(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = rnd14(v);
    if (r > SHF_MAX) r = SHF_MAX;
    if (r < SHF_MIN) r = SHF_MIN;
    return r[SW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/rqt_front.sv @@
// ----------------------------------------------------------------------------
// rqt_front
// input register, component products, norm and target-times-conjugate sums
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire rqt_pkg::q16_t   dest_i [4],
  input  wire rqt_pkg::q16_t   src_i  [4],
  output rqt_pkg::div_ctl_t    ctl_o,
  output logic [rqt_pkg::MW-1:0] mag_o [4],
  output logic [rqt_pkg::NW-1:0] norm_o
);

  logic                              vld1_q, vld2_q;
  rqt_pkg::q16_t                     d_q [4];
  rqt_pkg::q16_t                     s_q [4];
  logic signed [rqt_pkg::PRW-1:0]    pr_q [4][4];
  logic signed [rqt_pkg::PRW-1:0]    sq_q [4];
  logic signed [rqt_pkg::PW-1:0]     p_d [4];
  logic [rqt_pkg::NW-1:0]            n_d;
  rqt_pkg::div_ctl_t                 ctl_d, ctl_q;
  logic [rqt_pkg::MW-1:0]            mag_d [4], mag_q [4];
  logic [rqt_pkg::NW-1:0]            n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      ctl_q  <= '0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      d_q[i]  <= dest_i[i];
      s_q[i]  <= src_i[i];
      sq_q[i] <= rqt_pkg::PRW'(s_q[i]) * rqt_pkg::PRW'(s_q[i]);
      for (int j = 0; j < 4; j++) begin
        pr_q[i][j] <= rqt_pkg::PRW'(d_q[i]) * rqt_pkg::PRW'(s_q[j]);
      end
    end
    for (int i = 0; i < 4; i++) mag_q[i] <= mag_d[i];
    n_q <= n_d;
  end

  // P = D * conj(S), N = |S|^2
  always_comb begin
    p_d[0] =  rqt_pkg::PW'(pr_q[0][0]) + rqt_pkg::PW'(pr_q[1][1])
            + rqt_pkg::PW'(pr_q[2][2]) + rqt_pkg::PW'(pr_q[3][3]);
    p_d[1] = -rqt_pkg::PW'(pr_q[0][1]) + rqt_pkg::PW'(pr_q[1][0])
            - rqt_pkg::PW'(pr_q[2][3]) + rqt_pkg::PW'(pr_q[3][2]);
    p_d[2] = -rqt_pkg::PW'(pr_q[0][2]) + rqt_pkg::PW'(pr_q[1][3])
            + rqt_pkg::PW'(pr_q[2][0]) - rqt_pkg::PW'(pr_q[3][1]);
    p_d[3] = -rqt_pkg::PW'(pr_q[0][3]) - rqt_pkg::PW'(pr_q[1][2])
            + rqt_pkg::PW'(pr_q[2][1]) + rqt_pkg::PW'(pr_q[3][0]);
    n_d = rqt_pkg::NW'(sq_q[0][rqt_pkg::PRW-2:0]) + rqt_pkg::NW'(sq_q[1][rqt_pkg::PRW-2:0])
        + rqt_pkg::NW'(sq_q[2][rqt_pkg::PRW-2:0]) + rqt_pkg::NW'(sq_q[3][rqt_pkg::PRW-2:0]);
    ctl_d.vld  = vld2_q;
    ctl_d.zero = (n_d == '0);
    for (int i = 0; i < 4; i++) begin
      ctl_d.neg[i] = p_d[i][rqt_pkg::PW-1];
      mag_d[i] = p_d[i][rqt_pkg::PW-1] ? rqt_pkg::MW'(-p_d[i]) : rqt_pkg::MW'(p_d[i]);
    end
  end

  assign ctl_o  = ctl_q;
  assign mag_o  = mag_q;
  assign norm_o = n_q;

endmodule

`default_nettype wire

@@ design/rqt_div.sv @@
// ----------------------------------------------------------------------------
// rqt_div
// four-lane pipelined restoring divider, one quotient bit per stage,
// rounded to nearest and clamped to the error limit
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rqt_pkg::div_ctl_t ctl_i,
  input  wire logic [rqt_pkg::MW-1:0] mag_i [4],
  input  wire logic [rqt_pkg::NW-1:0] norm_i,
  output logic                   vld_o,
  output rqt_pkg::e_t            e_o [4]
);

  localparam int unsigned NS = rqt_pkg::QBITS + 1;

  rqt_pkg::div_ctl_t             ctl_q [NS];
  logic [rqt_pkg::NUMW-1:0]      rem_q [NS][4];
  logic [rqt_pkg::QBITS-1:0]     quo_q [NS][4];
  logic [rqt_pkg::DENW-1:0]      den_q [NS];
  logic                          vld_q;
  rqt_pkg::e_t                   e_d [4], e_q [4];

  // entry: dividend carries the half-divisor bias for rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_q[0] <= '0;
    else         ctl_q[0] <= ctl_i;
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= {norm_i, 1'b0};
    for (int l = 0; l < 4; l++) begin
      rem_q[0][l] <= {mag_i[l], 15'd0} + rqt_pkg::NUMW'(norm_i);
      quo_q[0][l] <= '0;
    end
  end

  for (genvar j = 0; j < rqt_pkg::QBITS; j++) begin : g_stage
    localparam int unsigned K = rqt_pkg::QBITS - 1 - j;
    logic [rqt_pkg::CMPW-1:0] dsh;
    logic [3:0]               ge;

    always_comb begin
      dsh = rqt_pkg::CMPW'(den_q[j]) << K;
      for (int l = 0; l < 4; l++) ge[l] = rqt_pkg::CMPW'(rem_q[j][l]) >= dsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ctl_q[j+1] <= '0;
      else         ctl_q[j+1] <= ctl_q[j];
    end

    always_ff @(posedge clk_i) begin
      den_q[j+1] <= den_q[j];
      for (int l = 0; l < 4; l++) begin
        rem_q[j+1][l] <= ge[l] ? rem_q[j][l] - rqt_pkg::NUMW'(dsh) : rem_q[j][l];
        quo_q[j+1][l] <= {quo_q[j][l][rqt_pkg::QBITS-2:0], ge[l]};
      end
    end
  end

  // clamp, sign, zero source
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic [rqt_pkg::EW-1:0] m;
      m = (quo_q[NS-1][l] > rqt_pkg::E_LIMIT) ? rqt_pkg::E_LIMIT : quo_q[NS-1][l];
      if (ctl_q[NS-1].zero)     e_d[l] = '0;
      else if (ctl_q[NS-1].neg[l]) e_d[l] = -$signed(m);
      else                       e_d[l] = $signed(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= ctl_q[NS-1].vld;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) e_q[l] <= e_d[l];
  end

  assign vld_o = vld_q;
  assign e_o   = e_q;

endmodule

`default_nettype wire

@@ design/rqt_matrix.sv @@
// ----------------------------------------------------------------------------
// rqt_matrix
// error quaternion to saturated rotation matrix and translation column
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire rqt_pkg::e_t   e_i [4],
  input  wire rqt_pkg::q16_t arm_i,
  output logic               vld_o,
  output rqt_pkg::rot_t      rot_o [9],
  output rqt_pkg::shf_t      shf_o [3]
);

  // product slots
  localparam int unsigned IXX = 0, IYY = 1, IZZ = 2, IXY = 3, IXZ = 4;
  localparam int unsigned IYZ = 5, IXW = 6, IYW = 7, IZW = 8;

  logic [4:0]                       vld_q;
  logic signed [rqt_pkg::TW-1:0]    pp_q [9];
  logic signed [rqt_pkg::TW-1:0]    t_d [9], t_q [9];
  rqt_pkg::rot_t                    rot_q [9], rotd_q [9], roto_q [9];
  logic signed [rqt_pkg::AW-1:0]    ap_q [3];
  rqt_pkg::shf_t                    shf_q [3];
  logic signed [rqt_pkg::TW-1:0]    w, x, y, z;

  assign w = rqt_pkg::TW'(e_i[0]);
  assign x = rqt_pkg::TW'(e_i[1]);
  assign y = rqt_pkg::TW'(e_i[2]);
  assign z = rqt_pkg::TW'(e_i[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[3:0], vld_i};
  end

  always_comb begin
    t_d[0] = rqt_pkg::ONE_Q28 - (pp_q[IYY] <<< 1) - (pp_q[IZZ] <<< 1);
    t_d[1] = (pp_q[IXY] <<< 1) - (pp_q[IZW] <<< 1);
    t_d[2] = (pp_q[IXZ] <<< 1) + (pp_q[IYW] <<< 1);
    t_d[3] = (pp_q[IXY] <<< 1) + (pp_q[IZW] <<< 1);
    t_d[4] = rqt_pkg::ONE_Q28 - (pp_q[IXX] <<< 1) - (pp_q[IZZ] <<< 1);
    t_d[5] = (pp_q[IYZ] <<< 1) - (pp_q[IXW] <<< 1);
    t_d[6] = (pp_q[IXZ] <<< 1) - (pp_q[IYW] <<< 1);
    t_d[7] = (pp_q[IYZ] <<< 1) + (pp_q[IXW] <<< 1);
    t_d[8] = rqt_pkg::ONE_Q28 - (pp_q[IXX] <<< 1) - (pp_q[IYY] <<< 1);
  end

  always_ff @(posedge clk_i) begin
    pp_q[IXX] <= x * x;
    pp_q[IYY] <= y * y;
    pp_q[IZZ] <= z * z;
    pp_q[IXY] <= x * y;
    pp_q[IXZ] <= x * z;
    pp_q[IYZ] <= y * z;
    pp_q[IXW] <= x * w;
    pp_q[IYW] <= y * w;
    pp_q[IZW] <= z * w;
    for (int i = 0; i < 9; i++) begin
      t_q[i]    <= t_d[i];
      rot_q[i]  <= rqt_pkg::sat_rot(t_q[i]);
      rotd_q[i] <= rot_q[i];
      roto_q[i] <= rotd_q[i];
    end
    for (int c = 0; c < 3; c++) begin
      ap_q[c]  <= rqt_pkg::AW'(arm_i) * rqt_pkg::AW'(rot_q[3*c]);
      shf_q[c] <= rqt_pkg::sat_shf(rqt_pkg::TW'(ap_q[c]));
    end
  end

  assign vld_o = vld_q[4];
  assign rot_o = roto_q;
  assign shf_o = shf_q;

endmodule

`default_nettype wire

@@ design/relative_quaternion_to_transform.sv @@
// ----------------------------------------------------------------------------
// relative_quaternion_to_transform
// error rotation between a target and a source quaternion, as a 3x3 matrix
// plus a translation column scaled by the arm length
// ----------------------------------------------------------------------------
//  channel   | signals                                | handshake
//  ----------+----------------------------------------+--------------------------
//  command   | start, busy, dest_*_i, src_*_i         | start & !busy
//  result    | out_valid_o, rot_*_o, shift_*_o        | one-cycle strobe
//  config    | cfg_valid_i, cfg_ready_o, cfg_data_i   | valid & ready
//
//  one transaction per cycle; the depth is set by the 32-stage restoring
//  divider (one quotient bit per stage)
//  busy stays low, so a command is taken every cycle
//  async active-low reset clears valid bits and sets arm length to zero
//  the receiver cannot stall, so nothing ever holds in the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module relative_quaternion_to_transform (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // command
  input  wire logic          start,
  output logic               busy,
  input  wire rqt_pkg::q16_t dest_w_i,
  input  wire rqt_pkg::q16_t dest_x_i,
  input  wire rqt_pkg::q16_t dest_y_i,
  input  wire rqt_pkg::q16_t dest_z_i,
  input  wire rqt_pkg::q16_t src_w_i,
  input  wire rqt_pkg::q16_t src_x_i,
  input  wire rqt_pkg::q16_t src_y_i,
  input  wire rqt_pkg::q16_t src_z_i,
  // configuration
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire rqt_pkg::q16_t cfg_data_i,
  // result
  output logic               out_valid_o,
  output rqt_pkg::rot_t      rot_00_o,
  output rqt_pkg::rot_t      rot_01_o,
  output rqt_pkg::rot_t      rot_02_o,
  output rqt_pkg::rot_t      rot_10_o,
  output rqt_pkg::rot_t      rot_11_o,
  output rqt_pkg::rot_t      rot_12_o,
  output rqt_pkg::rot_t      rot_20_o,
  output rqt_pkg::rot_t      rot_21_o,
  output rqt_pkg::rot_t      rot_22_o,
  output rqt_pkg::shf_t      shift_x_o,
  output rqt_pkg::shf_t      shift_y_o,
  output rqt_pkg::shf_t      shift_z_o
);

  rqt_pkg::q16_t              dest [4];
  rqt_pkg::q16_t              src  [4];
  rqt_pkg::div_ctl_t          front_ctl;
  logic [rqt_pkg::MW-1:0]     front_mag [4];
  logic [rqt_pkg::NW-1:0]     front_norm;
  logic                       err_vld;
  rqt_pkg::e_t                err [4];
  rqt_pkg::rot_t              rot [9];
  rqt_pkg::shf_t              shf [3];
  rqt_pkg::q16_t              arm_q;
  logic                       accept;

  // fully pipelined: never busy, config port always ready
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // arm length register; the user must write it only while the pipeline is empty, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      arm_q <= cfg_data_i;
    end
  end

  assign dest[0] = dest_w_i;
  assign dest[1] = dest_x_i;
  assign dest[2] = dest_y_i;
  assign dest[3] = dest_z_i;
  assign src[0]  = src_w_i;
  assign src[1]  = src_x_i;
  assign src[2]  = src_y_i;
  assign src[3]  = src_z_i;

  // norm and D * conj(S)
  rqt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .dest_i (dest),
    .src_i  (src),
    .ctl_o  (front_ctl),
    .mag_o  (front_mag),
    .norm_o (front_norm)
  );

  // E = P / N, 14 fraction bits, clamped
  rqt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (front_ctl),
    .mag_i  (front_mag),
    .norm_i (front_norm),
    .vld_o  (err_vld),
    .e_o    (err)
  );

  // matrix and translation column
  rqt_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (err_vld),
    .e_i    (err),
    .arm_i  (arm_q),
    .vld_o  (out_valid_o),
    .rot_o  (rot),
    .shf_o  (shf)
  );

  assign rot_00_o  = rot[0];
  assign rot_01_o  = rot[1];
  assign rot_02_o  = rot[2];
  assign rot_10_o  = rot[3];
  assign rot_11_o  = rot[4];
  assign rot_12_o  = rot[5];
  assign rot_20_o  = rot[6];
  assign rot_21_o  = rot[7];
  assign rot_22_o  = rot[8];
  assign shift_x_o = shf[0];
  assign shift_y_o = shf[1];
  assign shift_z_o = shf[2];

endmodule

`default_nettype wire

@@ design/rqt_checker.sv @@
// ----------------------------------------------------------------------------
// rqt_checker
// port-level checks on latency, zero-source identity and translation
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire rqt_pkg::q16_t src_w_i,
  input wire rqt_pkg::q16_t src_x_i,
  input wire rqt_pkg::q16_t src_y_i,
  input wire rqt_pkg::q16_t src_z_i,
  input wire logic          out_valid_o,
  input wire rqt_pkg::rot_t rot_00_o,
  input wire rqt_pkg::rot_t rot_01_o,
  input wire rqt_pkg::rot_t rot_11_o,
  input wire rqt_pkg::rot_t rot_10_o,
  input wire rqt_pkg::rot_t rot_20_o,
  input wire rqt_pkg::rot_t rot_22_o,
  input wire rqt_pkg::shf_t shift_y_o,
  input wire rqt_pkg::shf_t shift_z_o
);

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rqt_pkg::LATENCY) out_valid_o)
    else $error("result missing after latency");

  // no result without a matching command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, rqt_pkg::LATENCY))
    else $error("result without command");

  // zero source gives identity rotation
  a_zero_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && src_w_i == '0 && src_x_i == '0 && src_y_i == '0
     && src_z_i == '0) |-> ##(rqt_pkg::LATENCY)
    (rot_00_o == 16'sd16384 && rot_11_o == 16'sd16384 && rot_22_o == 16'sd16384
     && rot_01_o == '0 && rot_10_o == '0 && rot_20_o == '0))
    else $error("zero source not identity");

  // translation follows the first column
  a_shift_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rot_10_o == '0 && rot_20_o == '0) |->
    (shift_y_o == '0 && shift_z_o == '0))
    else $error("translation does not follow column");

endmodule

bind relative_quaternion_to_transform rqt_checker u_rqt_checker (.*);

`default_nettype wire

@@ tb/sv/rqt_checker.sv @@
// ----------------------------------------------------------------------------
// rqt_tb_checker
// watches the command, config and result channels, predicts each transform
// from the accepted quaternion pair and compares it field by field
// ----------------------------------------------------------------------------
module rqt_tb_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  rqt_pkg::q16_t dest_w_i,
  input  rqt_pkg::q16_t dest_x_i,
  input  rqt_pkg::q16_t dest_y_i,
  input  rqt_pkg::q16_t dest_z_i,
  input  rqt_pkg::q16_t src_w_i,
  input  rqt_pkg::q16_t src_x_i,
  input  rqt_pkg::q16_t src_y_i,
  input  rqt_pkg::q16_t src_z_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  rqt_pkg::q16_t cfg_data_i,
  input  logic          out_valid_o,
  input  rqt_pkg::rot_t rot_00_o,
  input  rqt_pkg::rot_t rot_01_o,
  input  rqt_pkg::rot_t rot_02_o,
  input  rqt_pkg::rot_t rot_10_o,
  input  rqt_pkg::rot_t rot_11_o,
  input  rqt_pkg::rot_t rot_12_o,
  input  rqt_pkg::rot_t rot_20_o,
  input  rqt_pkg::rot_t rot_21_o,
  input  rqt_pkg::rot_t rot_22_o,
  input  rqt_pkg::shf_t shift_x_o,
  input  rqt_pkg::shf_t shift_y_o,
  input  rqt_pkg::shf_t shift_z_o,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] rot [9];
    logic signed [16:0] shf [3];
  } pose_t;

  pose_t      pose_q [$];
  logic signed [15:0] arm_len;

  // quotient p * 2^14 / n, nearest, ties away, clamped to 2^30
  function automatic longint err_part(longint p, longint n);
    longint mag, q;
    mag = (p < 0) ? -p : p;
    q = ((mag <<< 15) + n) / (n <<< 1);
    if (q > (64'sd1 <<< 30)) q = 64'sd1 <<< 30;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint round_sat(longint v, longint lo, longint hi);
    longint mag, q, r;
    mag = (v < 0) ? -v : v;
    q = (mag + 8192) >>> 14;
    r = (v < 0) ? -q : q;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic pose_t predict_pose(longint d0, d1, d2, d3, s0, s1, s2, s3,
                                         longint arm);
    pose_t  t;
    longint n, w, x, y, z;
    longint m [9];
    w = 0; x = 0; y = 0; z = 0;
    n = s0*s0 + s1*s1 + s2*s2 + s3*s3;
    if (n > 0) begin
      w = err_part(d0*s0 + d1*s1 + d2*s2 + d3*s3, n);
      x = err_part(-d0*s1 + d1*s0 - d2*s3 + d3*s2, n);
      y = err_part(-d0*s2 + d1*s3 + d2*s0 - d3*s1, n);
      z = err_part(-d0*s3 - d1*s2 + d2*s1 + d3*s0, n);
    end
    m[0] = (64'sd1 <<< 28) - 2*y*y - 2*z*z;
    m[1] = 2*x*y - 2*z*w;
    m[2] = 2*x*z + 2*y*w;
    m[3] = 2*x*y + 2*z*w;
    m[4] = (64'sd1 <<< 28) - 2*x*x - 2*z*z;
    m[5] = 2*y*z - 2*x*w;
    m[6] = 2*x*z - 2*y*w;
    m[7] = 2*y*z + 2*x*w;
    m[8] = (64'sd1 <<< 28) - 2*x*x - 2*y*y;
    for (int i = 0; i < 9; i++) t.rot[i] = 16'(round_sat(m[i], -32768, 32767));
    for (int i = 0; i < 3; i++)
      t.shf[i] = 17'(round_sat(arm * longint'(t.rot[3*i]), -65536, 65535));
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    logic signed [15:0] got_r [9];
    logic signed [16:0] got_s [3];
    string nm;
    int nerr;
    nerr = 0;
    if (!rst_ni) begin
      arm_len    <= '0;
      fail_count <= 0;
      pending    <= 0;
      pose_q.delete();
    end else begin
      if (start && !busy)
        pose_q.push_back(predict_pose(dest_w_i, dest_x_i, dest_y_i, dest_z_i,
                                      src_w_i, src_x_i, src_y_i, src_z_i, arm_len));
      if (cfg_valid_i && cfg_ready_o) arm_len <= cfg_data_i;
      if (out_valid_o) begin
        got_r = '{rot_00_o, rot_01_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o,
                  rot_20_o, rot_21_o, rot_22_o};
        got_s = '{shift_x_o, shift_y_o, shift_z_o};
        if (pose_q.size() == 0) begin
          $error("result transaction with no expectation");
          nerr = nerr + 1;
        end else begin
          e = pose_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got_r[i] !== e.rot[i]) begin
              nm = $sformatf("rot_%0d%0d", i / 3, i % 3);
              $error("%s expected %0d actual %0d", nm, e.rot[i], got_r[i]);
              nerr = nerr + 1;
            end
          for (int i = 0; i < 3; i++)
            if (got_s[i] !== e.shf[i]) begin
              nm = (i == 0) ? "shift_x" : (i == 1) ? "shift_y" : "shift_z";
              $error("%s expected %0d actual %0d", nm, e.shf[i], got_s[i]);
              nerr = nerr + 1;
            end
        end
      end
      fail_count <= fail_count + nerr;
      pending    <= pose_q.size();
    end
  end
endmodule

@@ tb/sv/tb_relative_quaternion_to_transform.sv @@
// ----------------------------------------------------------------------------
// tb_relative_quaternion_to_transform
// drives directed and random quaternion pairs across several arm lengths,
// with random start gaps (none in one random phase); checking lives in rqt_tb_checker
// ----------------------------------------------------------------------------
module tb_relative_quaternion_to_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rqt_pkg::q16_t dest_w_i = '0, dest_x_i = '0, dest_y_i = '0, dest_z_i = '0;
  rqt_pkg::q16_t src_w_i = '0, src_x_i = '0, src_y_i = '0, src_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  rqt_pkg::q16_t cfg_data_i = '0;
  logic out_valid_o;
  rqt_pkg::rot_t rot_00_o, rot_01_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o;
  rqt_pkg::rot_t rot_20_o, rot_21_o, rot_22_o;
  rqt_pkg::shf_t shift_x_o, shift_y_o, shift_z_o;
  int   fail_count, pending;
  int   cycle_count = 0;
  bit   no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: ends a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  relative_quaternion_to_transform u_top (.*);

  rqt_tb_checker u_chk (.*);

  // one command transaction; start held until accepted, random gap before
  task automatic send_pair(input rqt_pkg::q16_t dw, dx, dy, dz, sw, sx, sy, sz);
    while (!no_gaps && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    dest_w_i <= dw; dest_x_i <= dx; dest_y_i <= dy; dest_z_i <= dz;
    src_w_i <= sw; src_x_i <= sx; src_y_i <= sy; src_z_i <= sz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // arm length write only with the pipeline drained
  task automatic set_arm(input rqt_pkg::q16_t len);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (rqt_pkg::LATENCY + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random component: equally often full range, unit-scale, mid-scale or tiny
  function automatic rqt_pkg::q16_t rnd_comp();
    case ($urandom_range(3))
      0: return rqt_pkg::q16_t'($urandom);
      1: return rqt_pkg::q16_t'($signed($urandom_range(32768)) - 16384);
      2: return rqt_pkg::q16_t'($signed($urandom_range(64)) - 32);
      default: return rqt_pkg::q16_t'($signed($urandom_range(12000)) - 6000);
    endcase
  endfunction

  task automatic random_phase(input int count);
    rqt_pkg::q16_t c [8];
    for (int k = 0; k < count; k++) begin
      foreach (c[j]) c[j] = rnd_comp();
      // zero source now and then
      if ($urandom_range(19) == 0) begin c[4] = 0; c[5] = 0; c[6] = 0; c[7] = 0; end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
  endtask

  initial begin
    rqt_pkg::q16_t arms [5] = '{16'sd100, -16'sd32768, 16'sd32767, -16'sd7, 16'sd1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset arm length of zero
    send_pair(16384, 0, 0, 0, 16384, 0, 0, 0);
    set_arm(16'sd1000);
    // identity, zero source, extremes, tiny source, non-unit, rotations
    send_pair(16384, 0, 0, 0, 16384, 0, 0, 0);
    send_pair(12345, -222, 333, 444, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
    send_pair(32767, 32767, -32768, 0, 1, 0, 0, 0);
    send_pair(-32768, 0, 32767, -32768, 0, 0, 0, -1);
    send_pair(16384, 0, 0, 0, 0, 1, 0, 0);
    send_pair(11585, 11585, 0, 0, 16384, 0, 0, 0);
    send_pair(11585, 0, 11585, 0, 11585, 0, 0, 11585);
    send_pair(0, 0, 0, 16384, 16384, 0, 0, 0);
    send_pair(32767, 0, 0, 0, 8192, 0, 0, 0);
    send_pair(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192);
    send_pair(16384, 16384, 16384, 16384, 3, -2, 1, 0);

    // random phases across arm lengths, including both extremes
    foreach (arms[i]) begin
      set_arm(arms[i]);
      no_gaps = (i == 2);
      random_phase(220);
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (rqt_pkg::LATENCY + 4) @(posedge clk_i);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
